FILE: hdl/qvr_pkg.sv
// qvr_pkg: shared types, widths and constants of the quaternion vector rotator
// no dependencies; imported by every module under hdl
package qvr_pkg;

  localparam int CompW   = 16;            // vector and quaternion component width
  localparam int ProdW   = 2 * CompW;     // product of two components
  localparam int KW      = 2 * CompW + 1; // w^2 - |u|^2 and |q|^2
  localparam int DotW    = 2 * CompW + 2; // u . v
  localparam int CrsW    = 2 * CompW + 1; // u x v
  localparam int NW      = 3 * CompW + 2; // numerator |q|^2 * rotated v
  localparam int AW      = 3 * CompW + 3; // rounded dividend 2|n| + |q|^2
  localparam int QW      = CompW + 1;     // quotient bits
  localparam int CfgIdxW = 2;

  typedef logic signed [CompW-1:0] comp_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [NW-1:0]    num_t;

  typedef struct packed {
    comp_t vec_x;
    comp_t vec_y;
    comp_t vec_z;
  } vec_t;

  typedef struct packed {
    comp_t rot_x;
    comp_t rot_y;
    comp_t rot_z;
  } rot_t;

  typedef struct packed {
    num_t nx;
    num_t ny;
    num_t nz;
  } nvec_t;

  // quaternion plus the two derived scalars the datapath needs
  typedef struct packed {
    comp_t                qw;
    comp_t                qi;
    comp_t                qj;
    comp_t                qk;
    logic signed [KW-1:0] kdiag; // w^2 - i^2 - j^2 - k^2
    logic [KW-1:0]        norm;  // w^2 + i^2 + j^2 + k^2
  } coef_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgQuatReal = 2'd0,
    CfgQuatI    = 2'd1,
    CfgQuatJ    = 2'd2,
    CfgQuatK    = 2'd3
  } cfg_reg_e;

  localparam comp_t QuatRealRst = comp_t'(1) << (CompW - 2);

endpackage

FILE: hdl/quaternion_vector_rotate_top.sv
// quaternion_vector_rotate_top: rotates each vector transaction by q * (0,v) * q^-1
// throughput: one vector per cycle while out_ready_i is high; 4 multiply stages, then
// 20 divide stages: magnitude, overflow check, 17 one-bit quotient stages, saturate;
// bubbles fill before input stalls; reset: quaternion (16384, 0, 0, 0), the identity
// rotation, pipeline empty; depends on qvr_pkg and all qvr_* modules
module quaternion_vector_rotate_top import qvr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // vector input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vec_t               in_data_i,
  // rotated vector output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rot_t               out_data_o,
  // quaternion register writes
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  comp_t              cfg_data_i
);

  // quaternion plus w^2 - |u|^2 and |q|^2, the latter two registered twice
  // after a write; the first stage that uses them is the third, so a vector
  // accepted on the edge after a write already sees the new quaternion
  coef_t coef;

  // numerator transaction between the product and divide pipelines
  logic  num_valid;
  logic  num_ready;
  nvec_t num_data;

  qvr_coef u_coef (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .coef_o     (coef)
  );

  // products: u*v, then dot and cross, then the three scaled terms, then
  // their sum, the exact numerator |q|^2 * rotated vector
  qvr_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .coef_i      (coef),
    .out_valid_o (num_valid),
    .out_ready_i (num_ready),
    .out_data_o  (num_data)
  );

  // rounding divide by |q|^2 with saturation; a zero quaternion gives zero
  qvr_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (num_valid),
    .in_ready_o  (num_ready),
    .in_data_i   (num_data),
    .coef_i      (coef),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: hdl/qvr_coef.sv
// qvr_coef: quaternion registers and the registered w^2 - |u|^2 and |q|^2 terms
// depends on qvr_pkg
module qvr_coef import qvr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  comp_t              cfg_data_i,
  output coef_t              coef_o
);

  comp_t quat_real_q, quat_real_d;
  comp_t quat_i_q, quat_i_d;
  comp_t quat_j_q, quat_j_d;
  comp_t quat_k_q, quat_k_d;

  prod_t ww_q, aa_q, bb_q, cc_q;
  prod_t ww_d, aa_d, bb_d, cc_d;

  logic signed [KW-1:0] kdiag_q, kdiag_d;
  logic [KW-1:0]        norm_q, norm_d;

  always_comb begin
    quat_real_d = quat_real_q;
    quat_i_d    = quat_i_q;
    quat_j_d    = quat_j_q;
    quat_k_d    = quat_k_q;
    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CfgQuatReal: quat_real_d = cfg_data_i;
        CfgQuatI:    quat_i_d    = cfg_data_i;
        CfgQuatJ:    quat_j_d    = cfg_data_i;
        CfgQuatK:    quat_k_d    = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    ww_d    = ProdW'(quat_real_q) * ProdW'(quat_real_q);
    aa_d    = ProdW'(quat_i_q) * ProdW'(quat_i_q);
    bb_d    = ProdW'(quat_j_q) * ProdW'(quat_j_q);
    cc_d    = ProdW'(quat_k_q) * ProdW'(quat_k_q);
    kdiag_d = KW'(ww_q) - KW'(aa_q) - KW'(bb_q) - KW'(cc_q);
    norm_d  = $unsigned(KW'(ww_q) + KW'(aa_q) + KW'(bb_q) + KW'(cc_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_real_q <= QuatRealRst;
      quat_i_q    <= '0;
      quat_j_q    <= '0;
      quat_k_q    <= '0;
      ww_q        <= ProdW'(1) << (2 * CompW - 4);
      aa_q        <= '0;
      bb_q        <= '0;
      cc_q        <= '0;
      kdiag_q     <= KW'(1) << (2 * CompW - 4);
      norm_q      <= KW'(1) << (2 * CompW - 4);
    end else begin
      quat_real_q <= quat_real_d;
      quat_i_q    <= quat_i_d;
      quat_j_q    <= quat_j_d;
      quat_k_q    <= quat_k_d;
      ww_q        <= ww_d;
      aa_q        <= aa_d;
      bb_q        <= bb_d;
      cc_q        <= cc_d;
      kdiag_q     <= kdiag_d;
      norm_q      <= norm_d;
    end
  end

  assign coef_o.qw    = quat_real_q;
  assign coef_o.qi    = quat_i_q;
  assign coef_o.qj    = quat_j_q;
  assign coef_o.qk    = quat_k_q;
  assign coef_o.kdiag = kdiag_q;
  assign coef_o.norm  = norm_q;

endmodule

FILE: hdl/qvr_mac.sv
// qvr_mac: four-stage product pipeline giving n = |q|^2 * rotated vector
// depends on qvr_pkg; coefficients come from qvr_coef
module qvr_mac import qvr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  vec_t  in_data_i,
  input  coef_t coef_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output nvec_t out_data_o
);

  localparam int NS  = 4;
  localparam int KvW = KW + CompW;
  localparam int DuW = DotW + CompW;
  localparam int WeW = CompW + CrsW;

  logic [NS-1:0] vld_q, vld_d, rdy, ld;

  comp_t vin [3];
  comp_t u [3];
  prod_t prod_d [3][3];
  prod_t prod_q [3][3];
  comp_t v1_q [3];
  comp_t v2_q [3];

  logic signed [DotW-1:0] dot_d, dot_q;
  logic signed [CrsW-1:0] crs_d [3];
  logic signed [CrsW-1:0] crs_q [3];
  logic signed [KvW-1:0]  kv_d [3];
  logic signed [KvW-1:0]  kv_q [3];
  logic signed [DuW-1:0]  du_d [3];
  logic signed [DuW-1:0]  du_q [3];
  logic signed [WeW-1:0]  we_d [3];
  logic signed [WeW-1:0]  we_q [3];
  num_t                   n_d [3];
  num_t                   n_q [3];

  assign vin[0] = in_data_i.vec_x;
  assign vin[1] = in_data_i.vec_y;
  assign vin[2] = in_data_i.vec_z;
  assign u[0]   = coef_i.qi;
  assign u[1]   = coef_i.qj;
  assign u[2]   = coef_i.qk;

  // a stage may move when the output is ready or some stage at or after it is empty
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = out_ready_i || !(&vld_q[NS-1:k]);
  end

  always_comb begin
    ld[0]    = rdy[0] && in_valid_i;
    vld_d[0] = rdy[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NS; k++) begin
      ld[k]    = rdy[k] && vld_q[k-1];
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_comb begin
    // stage 1: every u_i * v_j
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[i][j] = ProdW'(u[i]) * ProdW'(vin[j]);
      end
    end
    // stage 2: dot and cross products
    dot_d    = DotW'(prod_q[0][0]) + DotW'(prod_q[1][1]) + DotW'(prod_q[2][2]);
    crs_d[0] = CrsW'(prod_q[1][2]) - CrsW'(prod_q[2][1]);
    crs_d[1] = CrsW'(prod_q[2][0]) - CrsW'(prod_q[0][2]);
    crs_d[2] = CrsW'(prod_q[0][1]) - CrsW'(prod_q[1][0]);
    // stage 3 and 4: (w^2 - |u|^2) v + 2 (u.v) u + 2 w (u x v)
    for (int i = 0; i < 3; i++) begin
      kv_d[i] = KvW'(coef_i.kdiag) * KvW'(v2_q[i]);
      du_d[i] = DuW'(dot_q) * DuW'(u[i]);
      we_d[i] = WeW'(coef_i.qw) * WeW'(crs_q[i]);
      n_d[i]  = NW'(kv_q[i]) + (NW'(du_q[i]) << 1) + (NW'(we_q[i]) << 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      v1_q   <= vin;
      prod_q <= prod_d;
    end
    if (ld[1]) begin
      v2_q  <= v1_q;
      dot_q <= dot_d;
      crs_q <= crs_d;
    end
    if (ld[2]) begin
      kv_q <= kv_d;
      du_q <= du_d;
      we_q <= we_d;
    end
    if (ld[3]) begin
      n_q <= n_d;
    end
  end

  assign in_ready_o    = rdy[0];
  assign out_valid_o   = vld_q[NS-1];
  assign out_data_o.nx = n_q[0];
  assign out_data_o.ny = n_q[1];
  assign out_data_o.nz = n_q[2];

  // a held stage never drops its transaction
  a_mac_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((vld_q & ~rdy) != '0) |=> ((($past(vld_q) & ~$past(rdy)) & ~vld_q) == '0))
    else $error("mac stage lost a held transaction");

  // back pressure reaches the input only with every stage full
  a_mac_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> ((&vld_q) && !out_ready_i))
    else $error("mac input stalled with a free stage");

endmodule

FILE: hdl/qvr_div.sv
// qvr_div: pipelined rounding divide of n by |q|^2, one quotient bit per stage,
// then saturation to the component range; depends on qvr_pkg
module qvr_div import qvr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  nvec_t in_data_i,
  input  coef_t coef_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output rot_t  out_data_o
);

  // abs stage, overflow stage, QW quotient stages, saturate stage
  localparam int NS = QW + 3;

  logic [NS-1:0] vld_q, vld_d, rdy, ld;

  num_t          num_in [3];
  logic          abs_neg_d [3];
  logic          abs_neg_q [3];
  logic [AW-1:0] abs_num_d [3];
  logic [AW-1:0] abs_num_q [3];

  // index 0 is the overflow stage, index g the g-th quotient stage
  logic [AW-1:0] rem_d [QW][3];
  logic [AW-1:0] rem_q [QW][3];
  logic [QW-1:0] quo_d [QW+1][3];
  logic [QW-1:0] quo_q [QW+1][3];
  logic          neg_d [QW+1][3];
  logic          neg_q [QW+1][3];
  logic          ovf_d [QW+1][3];
  logic          ovf_q [QW+1][3];

  comp_t rot_d [3];
  comp_t rot_q [3];
  logic  zero_norm;

  assign num_in[0] = in_data_i.nx;
  assign num_in[1] = in_data_i.ny;
  assign num_in[2] = in_data_i.nz;
  assign zero_norm = (coef_i.norm == '0);

  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = out_ready_i || !(&vld_q[NS-1:k]);
  end

  always_comb begin
    ld[0]    = rdy[0] && in_valid_i;
    vld_d[0] = rdy[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NS; k++) begin
      ld[k]    = rdy[k] && vld_q[k-1];
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_comb begin
    logic [NW-1:0] mag;
    logic [AW-1:0] trial;
    logic [QW-1:0] lim;
    logic [QW-1:0] qsat;
    logic [QW-1:0] res;
    int            sh;
    for (int l = 0; l < 3; l++) begin
      // dividend 2|n| + s against divisor 2s gives round half away from zero
      abs_neg_d[l] = num_in[l][NW-1];
      mag          = abs_neg_d[l] ? $unsigned(-num_in[l]) : $unsigned(num_in[l]);
      abs_num_d[l] = {mag, 1'b0} + AW'(coef_i.norm);

      rem_d[0][l] = abs_num_q[l];
      quo_d[0][l] = '0;
      neg_d[0][l] = abs_neg_q[l];
      ovf_d[0][l] = abs_num_q[l] >= (AW'(coef_i.norm) << (CompW + 2));

      for (int g = 1; g <= QW; g++) begin
        sh    = QW - g;
        trial = AW'(coef_i.norm) << (sh + 1);
        quo_d[g][l] = quo_q[g-1][l];
        neg_d[g][l] = neg_q[g-1][l];
        ovf_d[g][l] = ovf_q[g-1][l];
        if (g < QW) begin
          rem_d[g][l] = rem_q[g-1][l];
        end
        if (rem_q[g-1][l] >= trial) begin
          quo_d[g][l] = quo_q[g-1][l] | (QW'(1) << sh);
          if (g < QW) begin
            rem_d[g][l] = rem_q[g-1][l] - trial;
          end
        end
      end

      lim = QW'(1) << (CompW - 1);
      if (!neg_q[QW][l]) begin
        lim = lim - QW'(1);
      end
      qsat = (ovf_q[QW][l] || (quo_q[QW][l] > lim)) ? lim : quo_q[QW][l];
      res  = neg_q[QW][l] ? (QW'(0) - qsat) : qsat;
      rot_d[l] = zero_norm ? comp_t'(0) : $signed(res[CompW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld[0]) begin
      abs_neg_q <= abs_neg_d;
      abs_num_q <= abs_num_d;
    end
    for (int g = 0; g <= QW; g++) begin
      if (ld[g+1]) begin
        quo_q[g] <= quo_d[g];
        neg_q[g] <= neg_d[g];
        ovf_q[g] <= ovf_d[g];
        if (g < QW) begin
          rem_q[g] <= rem_d[g];
        end
      end
    end
    if (ld[NS-1]) begin
      rot_q <= rot_d;
    end
  end

  assign in_ready_o       = rdy[0];
  assign out_valid_o      = vld_q[NS-1];
  assign out_data_o.rot_x = rot_q[0];
  assign out_data_o.rot_y = rot_q[1];
  assign out_data_o.rot_z = rot_q[2];

  a_div_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((vld_q & ~rdy) != '0) |=> ((($past(vld_q) & ~$past(rdy)) & ~vld_q) == '0))
    else $error("divide stage lost a held transaction");

  a_div_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> ((&vld_q) && !out_ready_i))
    else $error("divide input stalled with a free stage");

endmodule

FILE: bench/quaternion_vector_rotate_top_tb.sv
// quaternion_vector_rotate_top_tb: self-checking bench for the quaternion vector rotator
// predicts each rotated vector in 64-bit integer arithmetic and checks the output stream
// depends on qvr_pkg and quaternion_vector_rotate_top
module quaternion_vector_rotate_top_tb;
  import qvr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 200000;
  localparam int LongHold   = 300;   // cycles the receiver holds off when asked
  localparam int Settle     = 30;    // a little beyond the pipeline latency

  logic     clk_i;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  vec_t     in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  rot_t     out_data;
  logic     cfg_we    = 1'b0;
  cfg_reg_e cfg_idx   = CfgQuatReal;
  comp_t    cfg_data  = '0;

  quaternion_vector_rotate_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // shadow of the quaternion registers, starts at the reset value (16384, 0, 0, 0)
  comp_t quat_w = QuatRealRst;
  comp_t quat_i = '0;
  comp_t quat_j = '0;
  comp_t quat_k = '0;

  vec_t pending_vecs[$];     // vectors waiting to be offered, head is on the bus
  rot_t rotated_expect[$];   // predicted rotations, oldest first

  int errors = 0;
  int cycles = 0;
  int hold_req = 0;          // bumped by the sequencer to ask for a long receiver hold

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // divide numerator by |q|^2, round half away from zero, saturate to the component range
  function automatic comp_t round_sat(longint num, longint norm);
    longint mag;
    longint quo;
    longint lim;
    if (norm == 0) return '0;   // zero quaternion: every product is zero too
    mag = (num < 0) ? -num : num;
    quo = (2 * mag + norm) / (2 * norm);
    lim = (num < 0) ? (longint'(1) << (CompW - 1)) : (longint'(1) << (CompW - 1)) - 1;
    if (quo > lim) quo = lim;
    return (num < 0) ? comp_t'(-quo) : comp_t'(quo);
  endfunction

  // q * (0,v) * q^-1 through the closed form (w^2-|u|^2) v + 2 (u.v) u + 2 w (u x v)
  function automatic rot_t rotate_vec(vec_t v);
    longint w, a, b, c, x, y, z;
    longint norm, kdiag, dot;
    rot_t r;
    w = longint'(quat_w);
    a = longint'(quat_i);
    b = longint'(quat_j);
    c = longint'(quat_k);
    x = longint'(v.vec_x);
    y = longint'(v.vec_y);
    z = longint'(v.vec_z);
    norm  = w * w + a * a + b * b + c * c;
    kdiag = w * w - a * a - b * b - c * c;
    dot   = a * x + b * y + c * z;
    r.rot_x = round_sat(kdiag * x + 2 * dot * a + 2 * w * (b * z - c * y), norm);
    r.rot_y = round_sat(kdiag * y + 2 * dot * b + 2 * w * (c * x - a * z), norm);
    r.rot_z = round_sat(kdiag * z + 2 * dot * c + 2 * w * (a * y - b * x), norm);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers pending vectors in bursts with random gaps
  // ---------------------------------------------------------------------------
  int burst_left;
  int gap_left;
  logic accepted;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      accepted = in_valid && in_ready;
      if (accepted) begin
        // the quaternion only changes while idle, so the shadow is valid here
        rotated_expect.push_back(rotate_vec(pending_vecs.pop_front()));
      end
      // valid stays up with a stable payload until the transaction completes
      if (!in_valid || accepted) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_vecs.size() > 0) begin
          in_valid <= 1'b1;
          in_data  <= pending_vecs[0];
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // a quarter of the bursts run straight into the next one
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: ready pattern switches between always-on, light and heavy stalls
  // ---------------------------------------------------------------------------
  int hold_served;
  int hold_left;
  int stall_mode;
  int mode_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      hold_served = 0;
      hold_left   = 0;
      stall_mode  = 0;
      mode_left   = 0;
    end else begin
      if (hold_req != hold_served) begin
        hold_served = hold_req;
        hold_left   = LongHold;
      end
      if (hold_left > 0) begin
        // long hold-off, the pipeline fills and input backs up
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          mode_left  = $urandom_range(10, 60);
        end
        mode_left--;
        case (stall_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 1) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every output transaction against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, comp_t exp_val, comp_t act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  rot_t exp_rot;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (rotated_expect.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual (%0d, %0d, %0d)", $time,
                 out_data.rot_x, out_data.rot_y, out_data.rot_z);
        errors++;
      end else begin
        exp_rot = rotated_expect.pop_front();
        check_field("rot_x", exp_rot.rot_x, out_data.rot_x);
        check_field("rot_y", exp_rot.rot_y, out_data.rot_y);
        check_field("rot_z", exp_rot.rot_z, out_data.rot_z);
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               rotated_expect.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------

  // all four registers, back to back; called right after a rising edge
  task automatic write_quat(comp_t w, comp_t i, comp_t j, comp_t k);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgQuatReal;
    cfg_data <= w;
    @(posedge clk_i);
    cfg_idx  <= CfgQuatI;
    cfg_data <= i;
    @(posedge clk_i);
    cfg_idx  <= CfgQuatJ;
    cfg_data <= j;
    @(posedge clk_i);
    cfg_idx  <= CfgQuatK;
    cfg_data <= k;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    quat_w = w;
    quat_i = i;
    quat_j = j;
    quat_k = k;
    @(negedge clk_i);
  endtask

  task automatic queue_vec(int x, int y, int z);
    vec_t v;
    v.vec_x = comp_t'(x);
    v.vec_y = comp_t'(y);
    v.vec_z = comp_t'(z);
    pending_vecs.push_back(v);
  endtask

  // sender pause: everything offered, accepted and returned, pipeline drained
  task automatic drain();
    while (pending_vecs.size() != 0 || rotated_expect.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  // mostly full range, some small values near zero
  function automatic int rand_comp();
    if ($urandom_range(0, 4) == 0) return int'($urandom_range(0, 200)) - 100;
    return int'(comp_t'($urandom));
  endfunction

  // kind 0: full range, kind 1: small components (coarse |q|^2), kind 2: one axis cleared
  function automatic comp_t rand_quat_comp(int kind, bit clear);
    if (kind == 2 && clear) return '0;
    if (kind == 1) return comp_t'(int'($urandom_range(0, 64)) - 32);
    return comp_t'($urandom);
  endfunction

  int kind;
  int axis;
  int count;

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset quaternion is the identity: extremes pass straight through
    queue_vec(32767, -32768, 0);
    queue_vec(-32768, 32767, -1);
    queue_vec(1, -1, 0);
    queue_vec(0, 0, 0);
    queue_vec(-32768, -32768, -32768);
    queue_vec(32767, 32767, 32767);
    drain();

    // zero quaternion, |q|^2 = 0, all outputs forced to zero
    write_quat('0, '0, '0, '0);
    queue_vec(32767, -32768, 12345);
    queue_vec(-1, 1, -32768);
    drain();

    // half turn about x negates y and z, -(-32768) saturates
    write_quat('0, comp_t'(16384), '0, '0);
    queue_vec(0, -32768, -32768);
    queue_vec(5, -32768, 32767);
    drain();

    // unnormalized (1,1,1,1): |q|^2 = 4, the axes are cycled x to y to z
    write_quat(comp_t'(1), comp_t'(1), comp_t'(1), comp_t'(1));
    queue_vec(1, 0, 0);
    queue_vec(-1, 0, 0);
    queue_vec(3, -5, 7);
    queue_vec(-3, 5, -7);
    drain();

    // register extremes
    write_quat(comp_t'(-32768), comp_t'(-32768), comp_t'(-32768), comp_t'(-32768));
    queue_vec(32767, -32768, 12345);
    queue_vec(-32768, 32767, -1);
    drain();
    write_quat(comp_t'(32767), comp_t'(32767), comp_t'(32767), comp_t'(32767));
    queue_vec(-32768, 32767, -1);
    queue_vec(32767, 32767, -32768);
    drain();

    // random phases, each with a fresh quaternion
    for (int ph = 0; ph < 5; ph++) begin
      kind = (ph < 3) ? ph : $urandom_range(0, 2);
      axis = $urandom_range(0, 3);
      write_quat(rand_quat_comp(kind, axis == 0), rand_quat_comp(kind, axis == 1),
                 rand_quat_comp(kind, axis == 2), rand_quat_comp(kind, axis == 3));
      count = $urandom_range(100, 114);
      if (ph == 1) begin
        // receiver holds off while a full phase is offered
        hold_req++;
        for (int n = 0; n < count; n++) queue_vec(rand_comp(), rand_comp(), rand_comp());
      end else begin
        // split phase with a full drain in the middle
        for (int n = 0; n < count / 2; n++) queue_vec(rand_comp(), rand_comp(), rand_comp());
        drain();
        @(negedge clk_i);
        for (int n = count / 2; n < count; n++) queue_vec(rand_comp(), rand_comp(), rand_comp());
      end
      drain();
    end

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/qvr_pkg.sv
hdl/qvr_coef.sv
hdl/qvr_mac.sv
hdl/qvr_div.sv
hdl/quaternion_vector_rotate_top.sv
bench/quaternion_vector_rotate_top_tb.sv
